FILE: rtl/multi_task_watchdog_table_unit_defines.svh
// Assertion macros for the watchdog table unit.
// Used by the top level only; needs no other file.
`ifndef MULTI_TASK_WATCHDOG_TABLE_UNIT_DEFINES_SVH
`define MULTI_TASK_WATCHDOG_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MTWD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MTWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mtwd_pkg.sv
// Shared types and constants of the watchdog table unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtwd_pkg;

   // Sizing
   localparam int MAX_TASKS    = 10;
   localparam int TICK_RATE_HZ = 1000;
   localparam int MS_PER_S     = 1000;
   localparam int MASK_BITS    = 10;
   localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W        = $clog2(MAX_TASKS + 1);
   localparam int ID_W         = 8;
   localparam int TIME_W       = 32;
   localparam int CMD_W        = 2;
   localparam int STAT_W       = 2;
   // elapsed * rate (32 x 10 bits) and (timeout + 1) * 1000 (33 x 10 bits)
   localparam int PROD_W       = 48;
   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_REGISTER = 2'd1,
      CMD_KICK     = 2'd2,
      CMD_CHECK    = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FAIL    = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_NEW,
      WR_KICK,
      WR_UNKICK
   } wr_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_CHECK,
      FSM_DONE
   } fsm_type;

   // Slot table write request
   typedef struct packed {
      wr_op_type          op;
      logic [IDX_W-1:0]   idx;
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  stamp;
      logic [TIME_W-1:0]  timeout;
   } slot_wr_type;

   // Slot table read data
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               kicked;
      logic [TIME_W-1:0]  last_kick;
      logic [TIME_W-1:0]  timeout;
   } slot_rd_type;

   // Timeout unit issue
   typedef struct packed {
      logic               vld;
      logic [IDX_W-1:0]   idx;
      logic               kicked;
      logic [TIME_W-1:0]  last_kick;
      logic [TIME_W-1:0]  timeout;
   } chk_req_type;

   // Timeout unit verdict
   typedef struct packed {
      logic               vld;
      logic [IDX_W-1:0]   idx;
      logic               hit;
   } chk_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/multi_task_watchdog_table_unit.sv
// Watchdog table: clear, register, kick and check over up to MAX_TASKS slots.
// Clear and a rejected register go straight to the result hand-off state;
// register/kick search the used slots in turn; check walks the used slots
// and collects their verdicts. A next word can be taken in the cycle rsp_tvalid rises.
// A result unaccepted on rsp_tready holds the next one back in the hand-off state.
// Synchronous reset empties the table count and clears FSM and output valid.
`default_nettype none

module multi_task_watchdog_table_unit
   import mtwd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input words
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [7:0] client_id, [39:8] timeout, [71:40] now_ms
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // [1:0] cmd
   input  wire logic [CMD_W-1:0]       req_tuser,
   // Result words
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [1:0] status, [2] any_timeout, [12:3] timeout_mask, [15:13] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata
);

   fsm_type               state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [TIME_W-1:0]     tmo_ff, tmo_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   status_type            status_ff, status_in;
   logic                  any_ff, any_in;
   logic [MASK_BITS-1:0]  mask_ff, mask_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   slot_wr_type           slot_wr;
   slot_rd_type           slot_rd;
   chk_req_type           chk_req;
   chk_rsp_type           chk_rsp;

   logic                  req_fire;
   cmd_type               req_cmd;
   logic [ID_W-1:0]       req_id;
   logic [TIME_W-1:0]     req_tmo;
   logic [TIME_W-1:0]     req_now;

   // Input word fields
   assign req_cmd  = cmd_type'(req_tuser);
   assign req_id   = req_tdata[7:0];
   assign req_tmo  = req_tdata[39:8];
   assign req_now  = req_tdata[71:40];
   assign req_fire = req_tvalid && req_tready;

   mtwd_slot_table u_table (
      .clock  (clock),
      .wr     (slot_wr),
      .rd_idx (idx_ff[IDX_W-1:0]),
      .rd     (slot_rd)
   );

   mtwd_timeout_unit u_timeout (
      .clock   (clock),
      .reset   (reset),
      .now_ms  (now_ff),
      .chk_req (chk_req),
      .chk_rsp (chk_rsp)
   );

   // Sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      tmo_in        = tmo_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      any_in        = any_ff;
      mask_in       = mask_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = (state_ff == FSM_IDLE);

      slot_wr.op      = WR_NONE;
      slot_wr.idx     = idx_ff[IDX_W-1:0];
      slot_wr.id      = id_ff;
      slot_wr.stamp   = now_ff;
      slot_wr.timeout = tmo_ff;

      chk_req.vld       = 1'b0;
      chk_req.idx       = idx_ff[IDX_W-1:0];
      chk_req.kicked    = slot_rd.kicked;
      chk_req.last_kick = slot_rd.last_kick;
      chk_req.timeout   = slot_rd.timeout;

      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_cmd;
               id_in     = req_id;
               tmo_in    = req_tmo;
               now_in    = req_now;
               idx_in    = '0;
               any_in    = 1'b0;
               mask_in   = '0;
               status_in = STAT_OK;
               case (req_cmd)
                  CMD_CLEAR: begin
                     used_in  = '0;
                     state_in = FSM_DONE;
                  end
                  CMD_REGISTER: begin
                     if (req_id == '0 || req_tmo == '0) begin
                        status_in = STAT_INVALID;
                        state_in  = FSM_DONE;
                     end else if (used_ff == CNT_W'(MAX_TASKS)) begin
                        status_in = STAT_FAIL;
                        state_in  = FSM_DONE;
                     end else begin
                        state_in = FSM_SEARCH;
                     end
                  end
                  CMD_KICK: begin
                     state_in = FSM_SEARCH;
                  end
                  default: begin
                     state_in = FSM_CHECK;
                  end
               endcase
            end
         end

         // Id search, one slot per cycle
         FSM_SEARCH: begin
            if (idx_ff == used_ff) begin
               if (cmd_ff == CMD_REGISTER) begin
                  slot_wr.op  = WR_NEW;
                  slot_wr.idx = used_ff[IDX_W-1:0];
                  used_in     = used_ff + CNT_W'(1);
                  status_in   = STAT_OK;
               end else begin
                  status_in = STAT_FAIL;
               end
               state_in = FSM_DONE;
            end else if (slot_rd.id == id_ff) begin
               if (cmd_ff == CMD_REGISTER) begin
                  status_in = STAT_FAIL;
               end else begin
                  slot_wr.op = WR_KICK;
                  status_in  = STAT_OK;
               end
               state_in = FSM_DONE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // Timeout walk: issue one slot per cycle, collect verdicts
         FSM_CHECK: begin
            if (idx_ff != used_ff) begin
               chk_req.vld = 1'b1;
               slot_wr.op  = WR_UNKICK;
               idx_in      = idx_ff + CNT_W'(1);
            end else if (!chk_rsp.vld) begin
               state_in = FSM_DONE;
            end
            if (chk_rsp.vld && chk_rsp.hit) begin
               any_in = 1'b1;
               for (int b = 0; b < MASK_BITS; b++) begin
                  if (int'(chk_rsp.idx) == b) begin
                     mask_in[b] = 1'b1;
                  end
               end
            end
         end

         // Hand the result to the output register
         FSM_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{(RSP_DATA_W - MASK_BITS - 1 - STAT_W){1'b0}},
                                mask_ff, any_ff, status_ff};
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         used_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      tmo_ff       <= tmo_in;
      now_ff       <= now_in;
      idx_ff       <= idx_in;
      status_ff    <= status_in;
      any_ff       <= any_in;
      mask_ff      <= mask_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
`include "multi_task_watchdog_table_unit_defines.svh"

   `MTWD_ASSERT_NOW(a_used_bound, clock, reset, 1'b1,
      used_ff <= CNT_W'(MAX_TASKS), "slot count above table size")
   `MTWD_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire,
      state_ff != FSM_IDLE, "accepted word left sequencer idle")
   `MTWD_ASSERT_NOW(a_flags_only_on_check, clock, reset,
      state_ff == FSM_DONE && cmd_ff != CMD_CHECK,
      !any_ff && mask_ff == '0, "timeout flags on a non-check command")
   `MTWD_ASSERT_NOW(a_verdict_in_check, clock, reset, chk_rsp.vld,
      state_ff == FSM_CHECK, "timeout verdict outside the check walk")

endmodule

`default_nettype wire

FILE: rtl/mtwd_slot_table.sv
// Slot register file: id, kicked mark, last kick time and timeout per slot.
// One write port, one read port. Depends on mtwd_pkg.
`default_nettype none

module mtwd_slot_table
   import mtwd_pkg::*;
(
   input  wire logic              clock,
   input  wire slot_wr_type       wr,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output slot_rd_type            rd
);

   logic [ID_W-1:0]   id_ff     [MAX_TASKS];
   logic              kicked_ff [MAX_TASKS];
   logic [TIME_W-1:0] stamp_ff  [MAX_TASKS];
   logic [TIME_W-1:0] tmo_ff    [MAX_TASKS];

   // Write port: contents hold no reset value
   always_ff @(posedge clock) begin
      case (wr.op)
         WR_NEW: begin
            id_ff[wr.idx]     <= wr.id;
            kicked_ff[wr.idx] <= 1'b1;
            stamp_ff[wr.idx]  <= wr.stamp;
            tmo_ff[wr.idx]    <= wr.timeout;
         end
         WR_KICK: begin
            kicked_ff[wr.idx] <= 1'b1;
            stamp_ff[wr.idx]  <= wr.stamp;
         end
         WR_UNKICK: begin
            kicked_ff[wr.idx] <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Read port
   assign rd.id        = id_ff[rd_idx];
   assign rd.kicked    = kicked_ff[rd_idx];
   assign rd.last_kick = stamp_ff[rd_idx];
   assign rd.timeout   = tmo_ff[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/mtwd_timeout_unit.sv
// Shared timeout unit: one slot per cycle, two stages.
// Stage 1 registers elapsed*rate and (timeout+1)*1000; stage 2 compares.
// Depends on mtwd_pkg.
`default_nettype none

module mtwd_timeout_unit
   import mtwd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [TIME_W-1:0]  now_ms,
   input  wire chk_req_type        chk_req,
   output chk_rsp_type             chk_rsp
);

   logic [TIME_W-1:0] elapsed;
   logic [TIME_W:0]   tmo_p1;
   logic [PROD_W-1:0] scaled_in, scaled_ff;
   logic [PROD_W-1:0] limit_in, limit_ff;
   logic              vld_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              kicked_ff;

   // ticks > timeout  <=>  elapsed*rate >= (timeout+1)*1000
   always_comb begin
      elapsed   = now_ms - chk_req.last_kick;
      tmo_p1    = {1'b0, chk_req.timeout} + {{TIME_W{1'b0}}, 1'b1};
      scaled_in = PROD_W'(elapsed) * PROD_W'(TICK_RATE_HZ);
      limit_in  = PROD_W'(tmo_p1) * PROD_W'(MS_PER_S);
   end

   // Valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= chk_req.vld;
      end
   end

   // Product stage
   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      limit_ff  <= limit_in;
      idx_ff    <= chk_req.idx;
      kicked_ff <= chk_req.kicked;
   end

   // Compare stage
   assign chk_rsp.vld = vld_ff;
   assign chk_rsp.idx = idx_ff;
   assign chk_rsp.hit = !kicked_ff && (scaled_ff >= limit_ff);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the multi-task watchdog table unit: directed and random commands.
// Needs mtwd_pkg and multi_task_watchdog_table_unit; the scoreboard mirrors the slot table.

import mtwd_pkg::*;

// One expected result word
typedef struct packed {
   status_type             status;
   logic                   any_timeout;
   logic [MASK_BITS-1:0]   timeout_mask;
} watchdog_verdict;

// Mirror of the slot table plus the queue of verdicts still owed by the block
class watchdog_scoreboard;
   logic [ID_W-1:0]    slot_id [MAX_TASKS];
   bit                 slot_kicked [MAX_TASKS];
   logic [TIME_W-1:0]  slot_stamp [MAX_TASKS];
   logic [TIME_W-1:0]  slot_limit [MAX_TASKS];
   int unsigned        used_slots;
   watchdog_verdict    owed [$];
   int                 errors;
   int                 words_checked;
   int                 cmd_count [4];
   int                 flagged_checks;
   int                 failed_cmds;
   int                 invalid_cmds;

   function new();
      used_slots = 0;
      errors = 0;
      words_checked = 0;
      flagged_checks = 0;
      failed_cmds = 0;
      invalid_cmds = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
   endfunction

   function int outstanding();
      return owed.size();
   endfunction

   // Slot holding id among the used ones, or -1
   function int lookup(logic [ID_W-1:0] id);
      for (int i = 0; i < int'(used_slots); i++)
         if (slot_id[i] == id) return i;
      return -1;
   endfunction

   task report(string what);
      $display("ERROR @%0t: %s", $realtime, what);
      errors++;
   endtask

   // Apply one accepted command to the mirror and queue its verdict
   function void note_command(cmd_type cmd, logic [ID_W-1:0] id,
                              logic [TIME_W-1:0] tmo, logic [TIME_W-1:0] now);
      watchdog_verdict v;
      int s;
      logic [TIME_W-1:0] elapsed;
      longint unsigned ticks;
      v.status = STAT_OK;
      v.any_timeout = 1'b0;
      v.timeout_mask = '0;
      cmd_count[cmd]++;
      case (cmd)
         CMD_CLEAR: begin
            used_slots = 0;
         end
         CMD_REGISTER: begin
            // invalid beats full, full beats duplicate
            if (id == '0 || tmo == '0) begin
               v.status = STAT_INVALID;
            end else if (used_slots >= MAX_TASKS) begin
               v.status = STAT_FAIL;
            end else if (lookup(id) >= 0) begin
               v.status = STAT_FAIL;
            end else begin
               slot_id[used_slots] = id;
               slot_kicked[used_slots] = 1'b1;
               slot_stamp[used_slots] = now;
               slot_limit[used_slots] = tmo;
               used_slots++;
            end
         end
         CMD_KICK: begin
            s = lookup(id);
            if (s < 0) begin
               v.status = STAT_FAIL;
            end else begin
               slot_kicked[s] = 1'b1;
               slot_stamp[s] = now;
            end
         end
         default: begin
            // check: wrapped elapsed ms to ticks, compared in full width
            for (int i = 0; i < int'(used_slots); i++) begin
               elapsed = now - slot_stamp[i];
               ticks = longint'(elapsed) * longint'(TICK_RATE_HZ) / longint'(MS_PER_S);
               if (!slot_kicked[i] && ticks > longint'(slot_limit[i])) begin
                  v.any_timeout = 1'b1;
                  if (i < MASK_BITS) v.timeout_mask[i] = 1'b1;
               end
               slot_kicked[i] = 1'b0;
            end
            if (v.any_timeout) flagged_checks++;
         end
      endcase
      if (v.status == STAT_FAIL) failed_cmds++;
      if (v.status == STAT_INVALID) invalid_cmds++;
      owed.push_back(v);
   endfunction

   // Compare one accepted result word with the oldest verdict
   task check_result(logic [RSP_DATA_W-1:0] word);
      watchdog_verdict v;
      words_checked++;
      if (owed.size() == 0) begin
         report($sformatf("result word 0x%04h with nothing expected", word));
         return;
      end
      v = owed.pop_front();
      if (word[1:0] != v.status)
         report($sformatf("status %0d, expected %0d", word[1:0], v.status));
      if (word[2] != v.any_timeout)
         report($sformatf("any_timeout %0b, expected %0b", word[2], v.any_timeout));
      if (word[12:3] != v.timeout_mask)
         report($sformatf("timeout_mask 0x%03h, expected 0x%03h", word[12:3],
                          v.timeout_mask));
      if (word[15:13] != 3'b000)
         report($sformatf("pad bits 0x%0h, expected zero", word[15:13]));
   endtask
endclass

module testbench;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 250;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // [7:0] client_id, [39:8] timeout, [71:40] now_ms
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // [1:0] cmd
   logic [CMD_W-1:0]        req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [1:0] status, [2] any_timeout, [12:3] timeout_mask, [15:13] zero
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   int                      tx_idle_pct = 0;
   int                      rx_idle_pct = 0;
   int                      cycles = 0;
   logic [TIME_W-1:0]       wall_ms;
   watchdog_scoreboard      sb = new();

   multi_task_watchdog_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed", cycles, sb.outstanding());
         $display("testbench failed");
         $finish;
      end
   end

   // Present one command word and hold it until accepted
   task automatic send_word(input cmd_type cmd, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] now);
      // each cycle before the word goes out is idle with the sender's odds
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {now, tmo, id};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, id, tmo, now);
   endtask

   // Stop sending until every owed word has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Random command, biased toward a small id pool and short timeouts
   task automatic send_random_word();
      int r;
      cmd_type cmd;
      logic [ID_W-1:0] id;
      logic [TIME_W-1:0] tmo;
      logic [TIME_W-1:0] now;
      r = $urandom_range(99);
      if (r < 2) cmd = CMD_CLEAR;
      else if (r < 30) cmd = CMD_REGISTER;
      else if (r < 68) cmd = CMD_KICK;
      else cmd = CMD_CHECK;

      if (cmd == CMD_CLEAR || cmd == CMD_CHECK || $urandom_range(9) == 0)
         id = ID_W'($urandom_range(255));
      else
         id = ID_W'($urandom_range(1, 14));

      r = $urandom_range(99);
      if (cmd != CMD_REGISTER || r < 8) tmo = $urandom;
      else if (r < 16) tmo = '0;
      else tmo = TIME_W'($urandom_range(1, 60));

      // time mostly moves forward; now and then it jumps or nears the wrap
      r = $urandom_range(99);
      if (r < 4) begin
         now = $urandom;
      end else begin
         if (r < 6) wall_ms = 32'hFFFF_FFC0 + TIME_W'($urandom_range(63));
         else wall_ms = wall_ms + TIME_W'($urandom_range(40));
         now = wall_ms;
      end
      send_word(cmd, id, tmo, now);
   endtask

   initial begin
      int k;
      int phase;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: argument errors, duplicate, full table, boundaries, wrap
      wall_ms = 32'd1000;
      send_word(CMD_CLEAR, 8'd0, 32'd0, wall_ms);
      send_word(CMD_REGISTER, 8'd0, 32'd5, wall_ms);
      send_word(CMD_REGISTER, 8'd5, 32'd0, wall_ms);
      send_word(CMD_KICK, 8'd0, 32'hFFFF_FFFF, wall_ms);
      send_word(CMD_KICK, 8'd7, 32'd0, wall_ms);
      send_word(CMD_CHECK, 8'hFF, 32'hFFFF_FFFF, wall_ms);
      send_word(CMD_REGISTER, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
      send_word(CMD_REGISTER, 8'd1, 32'd10, wall_ms);
      send_word(CMD_REGISTER, 8'd1, 32'd3, wall_ms);
      // last slot stamped 1 ms later: elapsed equals its timeout at the check
      for (k = 2; k <= 9; k++)
         send_word(CMD_REGISTER, ID_W'(k), 32'd10, wall_ms + TIME_W'(k == 9));
      send_word(CMD_REGISTER, 8'd100, 32'd10, wall_ms);
      send_word(CMD_REGISTER, 8'd0, 32'd1, wall_ms);
      send_word(CMD_CHECK, 8'd0, 32'd0, wall_ms);
      send_word(CMD_KICK, 8'd2, 32'd0, wall_ms + 32'd5);
      send_word(CMD_CHECK, 8'd0, 32'd0, wall_ms + 32'd11);
      send_word(CMD_CHECK, 8'd0, 32'd0, wall_ms + 32'h8000_0000);
      send_word(CMD_KICK, 8'hFF, 32'd0, 32'd0);
      send_word(CMD_KICK, 8'd200, 32'd0, 32'd0);
      send_word(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_results_drained();

      // Random: receiver-heavy idling, then sender-heavy, then none
      wall_ms = $urandom;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 30;
               rx_idle_pct = 54;
            end
            1: begin
               tx_idle_pct = 54;
               rx_idle_pct = 30;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (n = 0; n < PHASE_WORDS; n++) begin
            send_random_word();
            if ($urandom_range(199) == 0) wait_results_drained();
         end
         wait_results_drained();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d commands: %0d clear, %0d register, %0d kick, %0d check.",
               sb.cmd_count[CMD_CLEAR] + sb.cmd_count[CMD_REGISTER] +
               sb.cmd_count[CMD_KICK] + sb.cmd_count[CMD_CHECK],
               sb.cmd_count[CMD_CLEAR], sb.cmd_count[CMD_REGISTER],
               sb.cmd_count[CMD_KICK], sb.cmd_count[CMD_CHECK]);
      $display("%0d result words compared; %0d checks flagged timeouts, %0d failures, %0d invalid.",
               sb.words_checked, sb.flagged_checks, sb.failed_cmds, sb.invalid_cmds);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/mtwd_pkg.sv
rtl/mtwd_slot_table.sv
rtl/mtwd_timeout_unit.sv
rtl/multi_task_watchdog_table_unit.sv
bench/testbench.sv
